### rtl/core/clme_pkg.sv
// Shared types, constants and helpers for the circular list move engine.
package clme_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int ITEM_W    = 10;
  localparam int COUNT_W   = 11;

  typedef logic [ITEM_W-1:0]  item_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_AFTER  = 2'd1,
    CMD_BEFORE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SAME  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_UNLINK,
    WR_LINK1,
    WR_LINK2
  } wr_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INIT,
    S_READ_T,
    S_CAP_T,
    S_UNLINK,
    S_READ_A,
    S_CAP_A,
    S_LINK1,
    S_LINK2,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_in;
    logic    start_init;
    logic    rd_en;
    logic    rd_sel_anchor;
    logic    cap_t;
    logic    cap_a;
    wr_op_t  wr_op;
    logic    load_out;
    status_t res_status;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic t_bad;
    logic a_bad;
    logic same;
    logic init_last;
    logic out_busy;
  } dp_stat_t;

  function automatic count_t clamp_count(input count_t n);
    count_t r;
    if (n < count_t'(2)) begin
      r = count_t'(2);
    end else if (n > count_t'(MAX_ITEMS)) begin
      r = count_t'(MAX_ITEMS);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

### rtl/core/circular_list_move_engine_core.sv
// Top level of the circular list move engine: controller plus datapath.
// A query reads the target's links; a move also unlinks the target, reads the anchor and
// relinks; a rejected or no-op request goes to the result; init rebuilds the clamped ring.
// Throughput: one request at a time, taken the cycle after the previous result enters the
// output register (a stalled result delays that); the dependent link accesses set the pace.
// Reset: synchronous, active high; clears the controller and the output valid and
// loads the stored item count and the ring size with 1024. Link memories are not cleared.
module circular_list_move_engine_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel: one register, the item count for the next init.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] item_count,
  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [9:0]  target_item,
  input  logic [9:0]  anchor_item,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  left_neighbour,
  output logic [9:0]  right_neighbour,
  output logic [1:0]  status
);
  import clme_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Configuration writes are for the user to make only while the engine is idle;
  // the block does not enforce this. The register can always take them.
  assign cfg_ready = 1'b1;

  // The controller walks each request through its link reads and writes.
  // It holds in_ready low from acceptance until the result is in the output
  // register, so the result register decouples the downstream stall.
  clme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // The datapath holds the successor and predecessor link memories, the
  // captured request, the link values read during a move, and the result.
  clme_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .item_count      (item_count),
    .command         (command),
    .target_item     (target_item),
    .anchor_item     (anchor_item),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .left_neighbour  (left_neighbour),
    .right_neighbour (right_neighbour),
    .status          (status)
  );

endmodule

### rtl/core/clme_ctrl.sv
// Sequencing state machine for the circular list move engine.
module clme_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  clme_pkg::dp_stat_t stat,
  output clme_pkg::dp_cmd_t  cmd
);
  import clme_pkg::*;

  state_t  state, state_next;
  status_t res_status, res_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_DONE;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        res_status_next = ST_DONE;
        unique case (stat.cmd)
          CMD_INIT: state_next = S_INIT;
          CMD_QUERY: begin
            if (stat.t_bad) begin
              res_status_next = ST_RANGE;
              state_next      = S_RESULT;
            end else begin
              state_next = S_READ_T;
            end
          end
          default: begin
            if (stat.t_bad || stat.a_bad) begin
              res_status_next = ST_RANGE;
              state_next      = S_RESULT;
            end else if (stat.same) begin
              res_status_next = ST_SAME;
              state_next      = S_RESULT;
            end else begin
              state_next = S_READ_T;
            end
          end
        endcase
      end
      S_INIT: begin
        if (stat.init_last) state_next = S_RESULT;
      end
      S_READ_T: state_next = S_CAP_T;
      S_CAP_T: begin
        state_next = (stat.cmd == CMD_QUERY) ? S_RESULT : S_UNLINK;
      end
      S_UNLINK: state_next = S_READ_A;
      S_READ_A: state_next = S_CAP_A;
      S_CAP_A:  state_next = S_LINK1;
      S_LINK1:  state_next = S_LINK2;
      S_LINK2:  state_next = S_RESULT;
      S_RESULT: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready          = 1'b0;
    cmd               = '0;
    cmd.wr_op         = WR_NONE;
    cmd.res_status    = res_status;
    unique case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_DISPATCH: cmd.start_init = (stat.cmd == CMD_INIT);
      S_INIT:     cmd.wr_op      = WR_INIT;
      S_READ_T:   cmd.rd_en      = 1'b1;
      S_CAP_T:    cmd.cap_t      = 1'b1;
      S_UNLINK:   cmd.wr_op      = WR_UNLINK;
      S_READ_A: begin
        cmd.rd_en         = 1'b1;
        cmd.rd_sel_anchor = 1'b1;
      end
      S_CAP_A:  cmd.cap_a    = 1'b1;
      S_LINK1:  cmd.wr_op    = WR_LINK1;
      S_LINK2:  cmd.wr_op    = WR_LINK2;
      S_RESULT: cmd.load_out = !stat.out_busy;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/clme_datapath.sv
// Link memories, request registers and result register of the list engine.
module clme_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [10:0]          item_count,
  input  logic [1:0]           command,
  input  logic [9:0]           target_item,
  input  logic [9:0]           anchor_item,
  input  clme_pkg::dp_cmd_t    cmd,
  output clme_pkg::dp_stat_t   stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [9:0]           left_neighbour,
  output logic [9:0]           right_neighbour,
  output logic [1:0]           status
);
  import clme_pkg::*;

  item_t  succ_mem [MAX_ITEMS];
  item_t  pred_mem [MAX_ITEMS];
  item_t  succ_rd, pred_rd;

  count_t cfg_count;
  count_t ring_size;
  cmd_t   cmd_q;
  item_t  t_q, a_q;
  item_t  p_q, n_q, x_q;
  item_t  idx;

  logic   succ_we, pred_we;
  item_t  succ_wa, succ_wd, pred_wa, pred_wd, rd_addr;
  logic   is_after, is_query_done;

  assign is_after = (cmd_q == CMD_AFTER);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_count <= count_t'(MAX_ITEMS);
      ring_size <= count_t'(MAX_ITEMS);
    end else begin
      if (cfg_valid) cfg_count <= item_count;
      if (cmd.start_init) ring_size <= clamp_count(cfg_count);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_q <= cmd_t'(command);
      t_q   <= target_item;
      a_q   <= anchor_item;
    end
    if (cmd.start_init) begin
      idx <= '0;
    end else if (cmd.wr_op == WR_INIT) begin
      idx <= idx + item_t'(1);
    end
    if (cmd.cap_t) begin
      p_q <= pred_rd;
      n_q <= succ_rd;
    end
    if (cmd.cap_a) x_q <= is_after ? succ_rd : pred_rd;
  end

  always_comb begin
    stat.cmd       = cmd_q;
    stat.t_bad     = {1'b0, t_q} >= ring_size;
    stat.a_bad     = {1'b0, a_q} >= ring_size;
    stat.same      = (t_q == a_q);
    stat.init_last = ({1'b0, idx} == (ring_size - count_t'(1)));
    stat.out_busy  = out_valid && !out_ready;
  end

  // Write port selection for both link memories.
  always_comb begin
    succ_we = 1'b0;
    pred_we = 1'b0;
    succ_wa = t_q;
    succ_wd = a_q;
    pred_wa = t_q;
    pred_wd = a_q;
    case (cmd.wr_op)
      WR_INIT: begin
        succ_we = 1'b1;
        pred_we = 1'b1;
        succ_wa = idx;
        pred_wa = idx;
        succ_wd = (({1'b0, idx} + count_t'(1)) == ring_size) ? '0 : idx + item_t'(1);
        pred_wd = (idx == '0) ? item_t'(ring_size - count_t'(1)) : idx - item_t'(1);
      end
      WR_UNLINK: begin
        succ_we = 1'b1;
        pred_we = 1'b1;
        succ_wa = p_q;
        succ_wd = n_q;
        pred_wa = n_q;
        pred_wd = p_q;
      end
      WR_LINK1: begin
        succ_we = 1'b1;
        pred_we = 1'b1;
        if (is_after) begin
          succ_wa = a_q;
          succ_wd = t_q;
          pred_wa = t_q;
          pred_wd = a_q;
        end else begin
          pred_wa = a_q;
          pred_wd = t_q;
          succ_wa = t_q;
          succ_wd = a_q;
        end
      end
      WR_LINK2: begin
        succ_we = 1'b1;
        pred_we = 1'b1;
        if (is_after) begin
          succ_wa = t_q;
          succ_wd = x_q;
          pred_wa = x_q;
          pred_wd = t_q;
        end else begin
          pred_wa = t_q;
          pred_wd = x_q;
          succ_wa = x_q;
          succ_wd = t_q;
        end
      end
      default: begin
        succ_we = 1'b0;
        pred_we = 1'b0;
      end
    endcase
  end

  assign rd_addr = cmd.rd_sel_anchor ? a_q : t_q;

  always_ff @(posedge clk) begin
    if (succ_we) succ_mem[succ_wa] <= succ_wd;
    if (cmd.rd_en) succ_rd <= succ_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pred_we) pred_mem[pred_wa] <= pred_wd;
    if (cmd.rd_en) pred_rd <= pred_mem[rd_addr];
  end

  // Result register; neighbors are only reported for a successful query.
  assign is_query_done = (cmd_q == CMD_QUERY) && (cmd.res_status == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      left_neighbour  <= is_query_done ? p_q : '0;
      right_neighbour <= is_query_done ? n_q : '0;
      status          <= cmd.res_status;
    end
  end

endmodule

### rtl/core/clme_checker.sv
// Port-level checker for the circular list move engine, bound to the top level.
module clme_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  left_neighbour,
  input logic [9:0]  right_neighbour,
  input logic [1:0]  status
);
  import clme_pkg::*;

  // Requests are processed one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another was in flight");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_neighbour)
      && $stable(right_neighbour) && $stable(status))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_DONE) || (status == ST_SAME) || (status == ST_RANGE))
    else $error("undefined status code");

  a_zero_on_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> left_neighbour == '0 && right_neighbour == '0)
    else $error("neighbors nonzero on rejected request");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind circular_list_move_engine_core clme_checker u_clme_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .left_neighbour  (left_neighbour),
  .right_neighbour (right_neighbour),
  .status          (status)
);
